>>> src/sensor_frame_receiver_defines.svh
// Assertion macros used by the serial multiplier module.
`ifndef SENSOR_FRAME_RECEIVER_DEFINES_SVH
`define SENSOR_FRAME_RECEIVER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset
`define SFR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset
`define SFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/sfr_pkg.sv
`default_nettype none

package sfr_pkg;

  localparam int BYTE_W = 8;
  localparam int MULT_W = 10;
  localparam int PPM_W  = 18;

  localparam logic [BYTE_W-1:0] START_BYTE = 8'hFF;
  localparam logic [BYTE_W-1:0] CMD_BYTE   = 8'h86;

  localparam logic [MULT_W-1:0] MULT_RESET = 10'd100;

  // Request from the frame parser to the serial multiplier
  typedef struct packed {
    logic              start;
    logic [BYTE_W-1:0] raw_high;
    logic [BYTE_W-1:0] raw_low;
  } sfr_launch_t;

endpackage

`default_nettype wire

>>> src/sfr_parser.sv
`default_nettype none

module sfr_parser (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      byte_valid,
  input  logic [sfr_pkg::BYTE_W-1:0] rx_byte,
  input  logic                      mult_busy,
  output logic                      byte_ready,
  output sfr_pkg::sfr_launch_t      launch
);
  import sfr_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_HEADER = 4'b0010,
    ST_DATA   = 4'b0100,
    ST_CHECK  = 4'b1000
  } state_t;

  // Frame byte positions seen in the data phase
  localparam logic [2:0] POS_FIRST = 3'd2;
  localparam logic [2:0] POS_HIGH  = 3'd2;
  localparam logic [2:0] POS_LOW   = 3'd3;
  localparam logic [2:0] POS_LAST  = 3'd7;

  state_t            state, state_next;
  logic [2:0]        pos;
  logic [BYTE_W-1:0] sum;
  logic [BYTE_W-1:0] sum_next;
  logic [BYTE_W-1:0] hi_byte;
  logic [BYTE_W-1:0] lo_byte;

  // running byte sum over frame bytes 1..7; the check byte must cancel it
  assign sum_next = sum + rx_byte;

  // hunt / collect sequence, one step per item
  always_comb begin
    state_next = state;
    if (byte_valid) begin
      case (state)
        ST_IDLE:   state_next = (rx_byte == START_BYTE) ? ST_HEADER : ST_IDLE;
        ST_HEADER: state_next = (rx_byte == CMD_BYTE) ? ST_DATA : ST_IDLE;
        ST_DATA:   state_next = (pos == POS_LAST) ? ST_CHECK : ST_DATA;
        ST_CHECK:  state_next = ST_IDLE;
        default:   state_next = ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pos   <= POS_FIRST;
    end else begin
      state <= state_next;
      if (byte_valid) begin
        if (state == ST_DATA) begin
          pos <= pos + 3'd1;
        end else begin
          pos <= POS_FIRST;
        end
      end
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (byte_valid) begin
      if (state == ST_HEADER) begin
        sum <= rx_byte;
      end else if (state == ST_DATA) begin
        sum <= sum_next;
        if (pos == POS_HIGH) begin
          hi_byte <= rx_byte;
        end
        if (pos == POS_LOW) begin
          lo_byte <= rx_byte;
        end
      end
    end
  end

  // the check byte waits while the multiplier still holds the last frame
  assign byte_ready = !(mult_busy && (state == ST_CHECK));

  assign launch.start    = byte_valid && (state == ST_CHECK) && (sum_next == '0);
  assign launch.raw_high = hi_byte;
  assign launch.raw_low  = lo_byte;

endmodule

`default_nettype wire

>>> src/sfr_serial_mult.sv
`default_nettype none
`include "sensor_frame_receiver_defines.svh"

module sfr_serial_mult (
  input  logic                       clk,
  input  logic                       rst,
  input  sfr_pkg::sfr_launch_t       launch,
  input  logic [sfr_pkg::MULT_W-1:0] multiplier,
  input  logic                       take,
  output logic                       busy,
  output logic                       done,
  output logic [sfr_pkg::PPM_W-1:0]  ppm_value,
  output logic [sfr_pkg::BYTE_W-1:0] raw_high,
  output logic [sfr_pkg::BYTE_W-1:0] raw_low
);
  import sfr_pkg::*;

  localparam int CNT_W = $clog2(BYTE_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(BYTE_W - 1);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  logic              running;
  logic [CNT_W-1:0]  cnt;
  logic [BYTE_W-1:0] mpr;
  logic [PPM_W-1:0]  mcand;
  logic [PPM_W-1:0]  acc;
  logic [BYTE_W-1:0] hi_dec;
  logic [BYTE_W-1:0] lo_dec;

  // BCD by arithmetic: tens nibble * 10 + units nibble, no digit check
  assign hi_dec = {1'b0, launch.raw_high[7:4], 3'b000}
                + {3'b000, launch.raw_high[7:4], 1'b0}
                + {4'b0000, launch.raw_high[3:0]};
  assign lo_dec = {1'b0, launch.raw_low[7:4], 3'b000}
                + {3'b000, launch.raw_low[7:4], 1'b0}
                + {4'b0000, launch.raw_low[3:0]};

  // control: run one bit per cycle, then hold the product until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      if (launch.start) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + CNT_ONE;
        if (cnt == CNT_LAST) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end else if (take) begin
        done <= 1'b0;
      end
    end
  end

  // shift-add datapath, LSB of the decoded high byte first
  always_ff @(posedge clk) begin
    if (launch.start) begin
      mpr      <= hi_dec;
      mcand    <= PPM_W'(multiplier);
      acc      <= PPM_W'(lo_dec);
      raw_high <= launch.raw_high;
      raw_low  <= launch.raw_low;
    end else if (running) begin
      if (mpr[0]) begin
        acc <= acc + mcand;
      end
      mpr   <= mpr >> 1;
      mcand <= mcand << 1;
    end
  end

  assign busy      = running || done;
  assign ppm_value = acc;

  `SFR_ASSERT_NOW(a_start_idle, launch.start, !running && !done, "launch while multiplier busy")
  `SFR_ASSERT_NOW(a_run_xor_done, running, !done, "running and done together")
  `SFR_ASSERT_NEXT(a_start_runs, launch.start, running, "launch did not start the multiply")
  `SFR_ASSERT_NEXT(a_done_holds, done && !take, done && $stable(acc), "product lost before taken")

endmodule

`default_nettype wire

>>> src/sensor_frame_receiver.sv
// Gas sensor reply parser. Each item is one received byte; the block hunts for
// 0xFF followed by 0x86, collects a nine-byte frame, and for a frame whose last
// byte cancels the byte sum of bytes 1..7 it emits one item carrying
// bcd(byte2) * ppm_multiplier + bcd(byte3) and the two raw bytes; bad frames
// are dropped without notice. Bytes are taken at one per cycle while in_ready
// is high. The checksum byte of a good frame starts a bit-serial shift-add
// multiply over the 8 bits of the decoded high byte; the product waits in the
// multiplier until the output register takes it, and the next frame's checksum
// byte is held off until then. Bytes that do not end a frame keep flowing while
// a result waits at the output. ppm_multiplier may be rewritten between frames
// through cfg_wr_en / cfg_wr_data (reset value 100).
`default_nettype none

module sensor_frame_receiver (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [sfr_pkg::MULT_W-1:0] cfg_wr_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [sfr_pkg::BYTE_W-1:0] rx_byte,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [sfr_pkg::PPM_W-1:0]  ppm_value,
  output logic [sfr_pkg::BYTE_W-1:0] raw_high,
  output logic [sfr_pkg::BYTE_W-1:0] raw_low
);
  import sfr_pkg::*;

  logic [MULT_W-1:0] ppm_multiplier;
  logic              in_fire;
  logic              mult_busy;
  logic              mult_done;
  logic              mult_take;
  sfr_launch_t       launch;
  logic [PPM_W-1:0]  mult_ppm;
  logic [BYTE_W-1:0] mult_high;
  logic [BYTE_W-1:0] mult_low;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      ppm_multiplier <= MULT_RESET;
    end else if (cfg_wr_en) begin
      ppm_multiplier <= cfg_wr_data;
    end
  end

  assign in_fire = in_valid && in_ready;

  sfr_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (in_fire),
    .rx_byte    (rx_byte),
    .mult_busy  (mult_busy),
    .byte_ready (in_ready),
    .launch     (launch)
  );

  sfr_serial_mult u_mult (
    .clk        (clk),
    .rst        (rst),
    .launch     (launch),
    .multiplier (ppm_multiplier),
    .take       (mult_take),
    .busy       (mult_busy),
    .done       (mult_done),
    .ppm_value  (mult_ppm),
    .raw_high   (mult_high),
    .raw_low    (mult_low)
  );

  // output register: load a finished product when the slot is free
  assign mult_take = mult_done && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (mult_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mult_take) begin
      ppm_value <= mult_ppm;
      raw_high  <= mult_high;
      raw_low   <= mult_low;
    end
  end

endmodule

`default_nettype wire

>>> bench/sensor_frame_receiver_test.sv
`timescale 1ns / 100ps

module sensor_frame_receiver_test;
  import sfr_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  // margin for the product to land after the checksum byte
  localparam int SETTLE_CYCLES = 20;
  localparam int FRAME_LEN = 9;
  localparam int PHASE_COUNT = 5;
  localparam int FRAMES_PER_PHASE = 10;
  localparam int SCRIPT_LEN = 30;

  typedef enum logic [2:0] {
    HUNT_START,
    HUNT_CMD,
    TAKE_BODY,
    TAKE_SUM,
    FRAME_DONE
  } frame_phase_t;

  typedef struct packed {
    logic [PPM_W-1:0]  ppm;
    logic [BYTE_W-1:0] high;
    logic [BYTE_W-1:0] low;
  } reading_t;

  // typed = 1: the row ends a good frame whose reading is written out here
  typedef struct packed {
    logic [BYTE_W-1:0] rx;
    logic              typed;
    reading_t          want;
  } script_row_t;

  localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
    // junk while hunting, then a start byte where the command belongs
    '{8'h00, 1'b0, '0},
    '{START_BYTE, 1'b0, '0},
    '{START_BYTE, 1'b0, '0},
    // all-zero reading
    '{START_BYTE, 1'b0, '0},
    '{CMD_BYTE, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h7A, 1'b1, '{18'd0, 8'h00, 8'h00}},
    // both reading bytes 0xFF: non-BCD nibbles, 165 each at multiplier 100
    '{START_BYTE, 1'b0, '0},
    '{CMD_BYTE, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h7C, 1'b1, '{18'd16665, 8'hFF, 8'hFF}},
    // bad checksum: dropped
    '{START_BYTE, 1'b0, '0},
    '{CMD_BYTE, 1'b0, '0},
    '{8'h99, 1'b0, '0},
    '{8'h01, 1'b0, '0},
    '{8'hAA, 1'b0, '0},
    '{8'h55, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    '{8'h00, 1'b0, '0}
  };

  logic              clk;
  logic              rst;
  logic              cfg_wr_en;
  logic [MULT_W-1:0] cfg_wr_data;
  logic              in_valid;
  logic              in_ready;
  logic [BYTE_W-1:0] rx_byte;
  logic              out_valid;
  logic              out_ready;
  logic [PPM_W-1:0]  ppm_value;
  logic [BYTE_W-1:0] raw_high;
  logic [BYTE_W-1:0] raw_low;

  // parser shadow state
  frame_phase_t      phase;
  logic [3:0]        position;
  logic [BYTE_W-1:0] frame_bytes [FRAME_LEN];
  logic [MULT_W-1:0] multiplier;

  reading_t readings_due [$];
  int       mismatches = 0;
  int       cycle_count = 0;
  bit       gaps_on = 1'b1;

  sensor_frame_receiver i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .rx_byte     (rx_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .ppm_value   (ppm_value),
    .raw_high    (raw_high),
    .raw_low     (raw_low)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int bcd_value(input logic [BYTE_W-1:0] b);
    return int'(b[7:4]) * 10 + int'(b[3:0]);
  endfunction

  // bias toward the extremes and a valid BCD pattern
  function automatic logic [BYTE_W-1:0] pick_byte();
    case ($urandom_range(7))
      0: return '0;
      1: return 8'hFF;
      2: return 8'h99;
      default: return BYTE_W'($urandom);
    endcase
  endfunction

  // Send one byte, then track the parser and queue any reading it completes.
  // Entered and left at a falling edge; valid stays up when bytes run back to back.
  task automatic feed_byte(input logic [BYTE_W-1:0] b, input logic typed,
                           input reading_t want);
    logic [BYTE_W-1:0] sum;
    logic [BYTE_W-1:0] check;
    reading_t          got;
    int                i;
    if (gaps_on) begin
      while ($urandom_range(99) < 10) begin
        in_valid = 1'b0;
        @(negedge clk);
      end
    end
    in_valid = 1'b1;
    rx_byte = b;
    do @(posedge clk); while (!in_ready);

    if (phase == HUNT_START) position = '0;
    case (phase)
      HUNT_START: if (b == START_BYTE) phase = HUNT_CMD;
      HUNT_CMD: phase = (b == CMD_BYTE) ? TAKE_BODY : HUNT_START;
      TAKE_BODY: if (position == FRAME_LEN - 2) phase = TAKE_SUM;
      TAKE_SUM: if (position == FRAME_LEN - 1) phase = FRAME_DONE;
      default: phase = HUNT_START;
    endcase
    if (position < FRAME_LEN) begin
      frame_bytes[position] = b;
      position = position + 4'd1;
    end

    // full frame: checksum test, then clear and hunt again
    if (phase == FRAME_DONE && position == FRAME_LEN) begin
      sum = '0;
      for (i = 1; i < 8; i++) sum = sum + frame_bytes[i];
      check = 8'd0 - sum;
      if (check == frame_bytes[8]) begin
        got.high = frame_bytes[2];
        got.low = frame_bytes[3];
        got.ppm = PPM_W'(bcd_value(got.high) * int'(multiplier) + bcd_value(got.low));
        if (!typed) readings_due.push_back(got);
      end
      foreach (frame_bytes[k]) frame_bytes[k] = '0;
      phase = HUNT_START;
    end
    if (typed) readings_due.push_back(want);
    @(negedge clk);
  endtask

  // receiver side stalls
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready = !gaps_on || ($urandom_range(99) >= 10);
    end
  end

  // compare each reading with the oldest one due
  always @(posedge clk) begin : check_readings
    reading_t want;
    if (!rst && out_valid && out_ready) begin
      if (readings_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected reading: ppm=%0d high=%h low=%h",
                   ppm_value, raw_high, raw_low);
      end else begin
        want = readings_due.pop_front();
        if (ppm_value !== want.ppm || raw_high !== want.high || raw_low !== want.low) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"reading mismatch: expected ppm=%0d high=%h low=%h, ",
                      "got ppm=%0d high=%h low=%h"},
                     want.ppm, want.high, want.low, ppm_value, raw_high, raw_low);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    logic [MULT_W-1:0] mult_plan [PHASE_COUNT];
    logic [BYTE_W-1:0] body [FRAME_LEN];
    logic [BYTE_W-1:0] sum;
    int                frame_len;
    int                ph;
    int                f;
    int                k;

    rst = 1'b1;
    in_valid = 1'b0;
    rx_byte = '0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    phase = HUNT_START;
    position = '0;
    foreach (frame_bytes[j]) frame_bytes[j] = '0;
    multiplier = MULT_RESET;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed frames at the reset multiplier
    foreach (SCRIPT[i]) feed_byte(SCRIPT[i].rx, SCRIPT[i].typed, SCRIPT[i].want);

    mult_plan[0] = '1;
    mult_plan[1] = '0;
    mult_plan[2] = MULT_W'(1);
    mult_plan[3] = MULT_W'($urandom_range(1022, 2));
    mult_plan[4] = MULT_W'($urandom);

    for (ph = 0; ph < PHASE_COUNT; ph++) begin
      // rewrite the multiplier only once the last product is out
      in_valid = 1'b0;
      while (readings_due.size() != 0) @(negedge clk);
      repeat (SETTLE_CYCLES) @(negedge clk);
      cfg_wr_en = 1'b1;
      cfg_wr_data = mult_plan[ph];
      multiplier = mult_plan[ph];
      @(negedge clk);
      cfg_wr_en = 1'b0;
      // one phase runs at full rate on both sides
      gaps_on = (ph != 2);

      for (f = 0; f < FRAMES_PER_PHASE; f++) begin
        // line noise between frames
        if ($urandom_range(99) < 15)
          repeat ($urandom_range(3, 1)) feed_byte(pick_byte(), 1'b0, '0);

        body[0] = START_BYTE;
        body[1] = CMD_BYTE;
        for (k = 2; k < 8; k++) body[k] = pick_byte();
        sum = '0;
        for (k = 1; k < 8; k++) sum = sum + body[k];
        body[8] = 8'd0 - sum;
        frame_len = FRAME_LEN;

        // broken frames: wrong command, cut short, bad checksum
        if ($urandom_range(99) < 8) begin
          body[1] = $urandom_range(1) ? START_BYTE : pick_byte();
          if (body[1] == CMD_BYTE) body[1] = CMD_BYTE + 8'd1;
          frame_len = 2;
        end else if ($urandom_range(99) < 5) begin
          frame_len = $urandom_range(FRAME_LEN - 1, 3);
        end else if ($urandom_range(99) < 15) begin
          body[8] = body[8] ^ (8'h01 << $urandom_range(7));
        end

        for (k = 0; k < frame_len; k++) feed_byte(body[k], 1'b0, '0);
      end
    end

    in_valid = 1'b0;
    while (readings_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

>>> sim.f
+incdir+src
src/sfr_pkg.sv
src/sfr_parser.sv
src/sfr_serial_mult.sv
src/sensor_frame_receiver.sv
bench/sensor_frame_receiver_test.sv
